// File: rtl/core/chm_pkg.sv
// Shared types and constants for the convex hull unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package chm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IO_BITS    = 16;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SADDR_W = $clog2(MAX_POINTS + 1);
  localparam int TOP_W   = $clog2(MAX_POINTS + 2);
  localparam int KEY_W   = 2 * COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [TOP_W-1:0]      top_t;

  // x sits in the upper half, so a plain vector compare gives x-then-y order.
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic   valid;
    point_t pt;
    logic   done;
    logic   overflow;
  } sort_out_t;

endpackage

// File: rtl/core/chm_if.sv
// Stream interfaces for point input and hull vertex output.
// Depends on chm_pkg for the field widths.
`timescale 1ns / 1ps

interface chm_point_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [IO_BITS-1:0] point_x;
  logic [IO_BITS-1:0] point_y;
  logic               set_end;
  modport source (output valid, point_x, point_y, set_end, input ready);
  modport sink   (input valid, point_x, point_y, set_end, output ready);
endinterface

interface chm_vertex_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [IO_BITS-1:0] vertex_x;
  logic [IO_BITS-1:0] vertex_y;
  logic               vertex_last;
  logic               overflow;
  modport source (output valid, vertex_x, vertex_y, vertex_last, overflow, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_last, overflow, output ready);
endinterface

// File: rtl/core/chm_sort.sv
// Point store and selection sort with duplicate removal.
// Depends on chm_pkg and chm_point_if.
`timescale 1ns / 1ps

module chm_sort import chm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  chm_point_if.sink   in_ch,
  input  logic        hull_done,
  output sort_out_t   so
);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_SCAN    = 3'b010,
    ST_WAIT    = 3'b100
  } st_t;

  point_t store_mem [MAX_POINTS];
  point_t rd_q;

  st_t        state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       idx_r, idx_nxt;
  logic       drop_r, drop_nxt;
  logic       dv_r, dv_nxt;
  logic       found_r, found_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic [KEY_W-1:0] best_r, best_nxt;
  logic [KEY_W-1:0] prev_r, prev_nxt;
  sort_out_t  so_r, so_nxt;

  logic       accept;
  logic       wr_en;
  logic       rd_en;
  logic [KEY_W-1:0] key;

  assign in_ch.ready = (state_r == ST_COLLECT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign wr_en       = accept && (cnt_r < cnt_t'(MAX_POINTS));
  assign rd_en       = (state_r == ST_SCAN) && (idx_r < cnt_r);
  assign key         = rd_q;
  assign so          = so_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[cnt_r[IDX_W-1:0]] <= '{x: coord_t'(in_ch.point_x), y: coord_t'(in_ch.point_y)};
    end
    if (rd_en) begin
      rd_q <= store_mem[idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    drop_nxt      = drop_r;
    dv_nxt        = 1'b0;
    found_nxt     = found_r;
    have_prev_nxt = have_prev_r;
    best_nxt      = best_r;
    prev_nxt      = prev_r;
    so_nxt        = '0;
    so_nxt.pt     = best_r;
    so_nxt.overflow = drop_r;
    case (state_r)
      ST_COLLECT: begin
        if (accept) begin
          if (wr_en) begin
            cnt_nxt = cnt_r + cnt_t'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_ch.set_end) begin
            state_nxt     = ST_SCAN;
            idx_nxt       = '0;
            found_nxt     = 1'b0;
            have_prev_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + cnt_t'(1);
          dv_nxt  = 1'b1;
        end
        // Keep the smallest point strictly above the one picked last pass.
        if (dv_r && (!have_prev_r || key > prev_r) && (!found_r || key < best_r)) begin
          best_nxt  = key;
          found_nxt = 1'b1;
        end
        if (!rd_en && !dv_r) begin
          if (found_r) begin
            so_nxt.valid  = 1'b1;
            prev_nxt      = best_r;
            have_prev_nxt = 1'b1;
            found_nxt     = 1'b0;
            idx_nxt       = '0;
          end else begin
            so_nxt.done = 1'b1;
            state_nxt   = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (hull_done) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      idx_r       <= '0;
      so_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      have_prev_r <= have_prev_nxt;
      idx_r       <= idx_nxt;
      so_r        <= so_nxt;
    end
    best_r <= best_nxt;
    prev_r <= prev_nxt;
  end

endmodule

// File: rtl/core/chm_hull.sv
// Sorted point buffer, hull stack and the chain builder with vertex output.
// Depends on chm_pkg and chm_vertex_if.
`timescale 1ns / 1ps

module chm_hull import chm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sort_out_t    so,
  output logic         hull_done,
  chm_vertex_if.source out_ch
);

  typedef enum logic [9:0] {
    H_LOAD = 10'b0000000001,
    H_RD   = 10'b0000000010,
    H_GET  = 10'b0000000100,
    H_CHK  = 10'b0000001000,
    H_MUL  = 10'b0000010000,
    H_CMP  = 10'b0000100000,
    H_POPW = 10'b0001000000,
    E_RD   = 10'b0010000000,
    E_LD   = 10'b0100000000,
    E_WT   = 10'b1000000000
  } hs_t;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int TURN_W = PROD_W + 1;

  point_t srt_mem [MAX_POINTS];
  point_t stk_mem [MAX_POINTS + 1];
  point_t srt_q, stk_q;

  hs_t    state_r, state_nxt;
  cnt_t   n_r, n_nxt;
  cnt_t   i_r, i_nxt;
  logic   upper_r, upper_nxt;
  top_t   top_r, top_nxt;
  top_t   lower_r, lower_nxt;
  top_t   e_idx_r, e_idx_nxt;
  top_t   nres_r, nres_nxt;
  logic   small_r, small_nxt;
  logic   ovf_r, ovf_nxt;
  logic   done_r, done_nxt;
  logic   ov_r, ov_nxt;
  point_t p_r, p_nxt;
  point_t s1_r, s1_nxt;
  point_t s2_r, s2_nxt;
  point_t vx_r, vx_nxt;
  logic   vlast_r, vlast_nxt;
  logic signed [PROD_W-1:0] pa_r, pb_r;

  logic   srt_rd_en, stk_rd_en, stk_wr_en;
  logic [IDX_W-1:0]   srt_rd_addr;
  logic [SADDR_W-1:0] stk_rd_addr;

  logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2;
  logic signed [TURN_W-1:0] turn;
  logic   push_ok;
  top_t   top_push;
  logic   chk_cond;

  assign out_ch.valid       = ov_r;
  assign out_ch.vertex_x    = IO_BITS'(vx_r.x);
  assign out_ch.vertex_y    = IO_BITS'(vx_r.y);
  assign out_ch.vertex_last = vlast_r;
  assign out_ch.overflow    = ovf_r;
  assign hull_done          = done_r;

  assign dx1  = $signed({1'b0, s1_r.x}) - $signed({1'b0, s2_r.x});
  assign dy1  = $signed({1'b0, s1_r.y}) - $signed({1'b0, s2_r.y});
  assign dx2  = $signed({1'b0, p_r.x}) - $signed({1'b0, s2_r.x});
  assign dy2  = $signed({1'b0, p_r.y}) - $signed({1'b0, s2_r.y});
  assign turn = TURN_W'(pa_r) - TURN_W'(pb_r);

  assign push_ok  = (top_r < top_t'(MAX_POINTS + 1));
  assign top_push = push_ok ? top_r + top_t'(1) : top_r;
  assign chk_cond = upper_r ? (top_r > lower_r) : (top_r >= top_t'(2));

  always_ff @(posedge clk) begin
    if (so.valid) begin
      srt_mem[n_r[IDX_W-1:0]] <= so.pt;
    end
    if (srt_rd_en) begin
      srt_q <= srt_mem[srt_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[top_r[SADDR_W-1:0]] <= p_r;
    end
    if (stk_rd_en) begin
      stk_q <= stk_mem[stk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == H_MUL) begin
      pa_r <= dx1 * dy2;
      pb_r <= dy1 * dx2;
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    upper_nxt = upper_r;
    top_nxt   = top_r;
    lower_nxt = lower_r;
    e_idx_nxt = e_idx_r;
    nres_nxt  = nres_r;
    small_nxt = small_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    ov_nxt    = ov_r;
    p_nxt     = p_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    vx_nxt    = vx_r;
    vlast_nxt = vlast_r;
    srt_rd_en   = 1'b0;
    srt_rd_addr = i_r[IDX_W-1:0];
    stk_rd_en   = 1'b0;
    stk_rd_addr = e_idx_r[SADDR_W-1:0];
    stk_wr_en   = 1'b0;
    case (state_r)
      H_LOAD: begin
        if (so.valid) begin
          n_nxt = n_r + cnt_t'(1);
        end
        if (so.done) begin
          ovf_nxt   = so.overflow;
          e_idx_nxt = '0;
          i_nxt     = '0;
          upper_nxt = 1'b0;
          top_nxt   = '0;
          if (n_r < cnt_t'(3)) begin
            small_nxt = 1'b1;
            nres_nxt  = top_t'(n_r);
            state_nxt = E_RD;
          end else begin
            small_nxt = 1'b0;
            state_nxt = H_RD;
          end
        end
      end
      H_RD: begin
        srt_rd_en = 1'b1;
        state_nxt = H_GET;
      end
      H_GET: begin
        p_nxt     = srt_q;
        state_nxt = H_CHK;
      end
      H_MUL: begin
        state_nxt = H_CMP;
      end
      H_POPW: begin
        s2_nxt    = stk_q;
        state_nxt = H_CHK;
      end
      E_RD: begin
        srt_rd_en   = small_r;
        srt_rd_addr = e_idx_r[IDX_W-1:0];
        stk_rd_en   = !small_r;
        state_nxt   = E_LD;
      end
      E_LD: begin
        vx_nxt    = small_r ? srt_q : stk_q;
        vlast_nxt = (e_idx_r + top_t'(1) == nres_r);
        ov_nxt    = 1'b1;
        state_nxt = E_WT;
      end
      E_WT: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (vlast_r) begin
            done_nxt  = 1'b1;
            n_nxt     = '0;
            state_nxt = H_LOAD;
          end else begin
            e_idx_nxt = e_idx_r + top_t'(1);
            state_nxt = E_RD;
          end
        end
      end
      default: begin
        state_nxt = H_LOAD;
      end
    endcase

    // Pop or push decisions shared by the check and compare steps.
    if ((state_r == H_CHK && chk_cond) ) begin
      state_nxt = H_MUL;
    end else if (state_r == H_CMP && turn <= 0) begin
      top_nxt = top_r - top_t'(1);
      s1_nxt  = s2_r;
      if (top_r >= top_t'(3)) begin
        stk_rd_en   = 1'b1;
        stk_rd_addr = SADDR_W'(top_r - top_t'(3));
        state_nxt   = H_POPW;
      end else begin
        state_nxt = H_CHK;
      end
    end else if (state_r == H_CHK || state_r == H_CMP) begin
      if (push_ok) begin
        stk_wr_en = 1'b1;
        s2_nxt    = s1_r;
        s1_nxt    = p_r;
      end
      top_nxt   = top_push;
      state_nxt = H_RD;
      if (!upper_r) begin
        if (i_r == n_r - cnt_t'(1)) begin
          lower_nxt = top_push;
          upper_nxt = 1'b1;
          i_nxt     = n_r - cnt_t'(2);
        end else begin
          i_nxt = i_r + cnt_t'(1);
        end
      end else if (i_r == '0) begin
        nres_nxt  = (top_push > top_t'(1)) ? top_push - top_t'(1) : top_push;
        e_idx_nxt = '0;
        state_nxt = E_RD;
      end else begin
        i_nxt = i_r - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_LOAD;
      n_r     <= '0;
      ov_r    <= 1'b0;
      done_r  <= 1'b0;
      i_r     <= '0;
      upper_r <= 1'b0;
      top_r   <= '0;
      lower_r <= '0;
      e_idx_r <= '0;
      nres_r  <= '0;
      small_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
      done_r  <= done_nxt;
      i_r     <= i_nxt;
      upper_r <= upper_nxt;
      top_r   <= top_nxt;
      lower_r <= lower_nxt;
      e_idx_r <= e_idx_nxt;
      nres_r  <= nres_nxt;
      small_r <= small_nxt;
    end
    ovf_r   <= ovf_nxt;
    p_r     <= p_nxt;
    s1_r    <= s1_nxt;
    s2_r    <= s2_nxt;
    vx_r    <= vx_nxt;
    vlast_r <= vlast_nxt;
  end

endmodule

// File: rtl/core/convex_hull_monotone_chain_unit.sv
// Top level of the convex hull unit: point store and sorter feeding the chain builder.
// Depends on chm_pkg, chm_if, chm_sort and chm_hull.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload                                   Transfer when
// in_ch     input      point_x, point_y, set_end                 valid && ready
// out_ch    output     vertex_x, vertex_y, vertex_last, overflow valid && ready
//
// After the set_end transfer the sorter makes u+1 passes over the point store (u
// being the number of unique stored points). For each sorted point the chain builder
// fetches it (H_RD, H_GET), checks the stack (H_CHK), runs the turn test (H_MUL,
// H_CMP) and, when a pop has to reload the stack, waits in H_POPW. Each vertex goes
// through E_RD, E_LD and E_WT, which waits out any stall on out_ch. The input stays
// closed from the set_end transfer and reopens after the last vertex transfer, once
// hull_done has reached the sorter. Reset is synchronous, active low, and clears
// only control state; the memories need no clearing.

module convex_hull_monotone_chain_unit import chm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  chm_point_if.sink    in_ch,
  chm_vertex_if.source out_ch
);

  // Sorted points flow one per transfer into the chain builder, which reports
  // back once the last vertex of the set has left.
  sort_out_t sorted;
  logic      hull_done;

  chm_sort u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .hull_done (hull_done),
    .so        (sorted)
  );

  chm_hull u_hull (
    .clk       (clk),
    .rst_n     (rst_n),
    .so        (sorted),
    .hull_done (hull_done),
    .out_ch    (out_ch)
  );

endmodule
